// ===== rtl/core/wcdma_cmt_pkg.sv =====
`default_nettype none
package wcdma_cmt_pkg;

	// record kinds
	localparam logic [1:0] KIND_IDENT = 2'd0;
	localparam logic [1:0] KIND_SERV  = 2'd1;
	localparam logic [1:0] KIND_MEAS  = 2'd2;

	// conversion and decode constants
	localparam int unsigned RSCP_OFFSET = 21;
	localparam int unsigned RSCP_FLOOR  = 140;
	localparam int unsigned ECNO_FLOOR  = 50;
	localparam int unsigned PSC_MAX     = 511;
	localparam int unsigned IDENT_W     = 28;
	localparam logic [3:0]  DIGIT_END   = 4'hF;
	localparam logic [3:0]  DIGIT_MAX   = 4'd9;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_item;
		logic srv_id_upd;
		logic srv_meas_upd;
		logic rd_start;
		logic rd_next;
		logic out_srv;
		logic out_nbr;
	} dp_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic ident_ok;
		logic is_meas;
		logic srv_match;
		logic tbl_empty;
		logic hit;
		logic last;
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/wcdma_cmt_ctrl.sv =====
`default_nettype none
module wcdma_cmt_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	input  wire wcdma_cmt_pkg::dp_sts_t sts,
	output wcdma_cmt_pkg::dp_cmd_t     cmd
);

	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_DECODE   = 5'b00010,
		ST_SEARCH   = 5'b00100,
		ST_EMIT_SRV = 5'b01000,
		ST_EMIT_NBR = 5'b10000
	} state_t;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// sequence one request through decode, search and report
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_nxt     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.ident_ok) begin
					cmd.srv_id_upd = 1'b1;
					state_nxt      = ST_EMIT_SRV;
				end else if (!sts.is_meas) begin
					state_nxt = ST_IDLE;
				end else if (sts.srv_match) begin
					cmd.srv_meas_upd = 1'b1;
					state_nxt        = ST_EMIT_SRV;
				end else if (sts.tbl_empty) begin
					state_nxt = ST_EMIT_NBR;
				end else begin
					cmd.rd_start = 1'b1;
					state_nxt    = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (sts.hit) begin
					state_nxt = ST_IDLE;
				end else if (sts.last) begin
					state_nxt = ST_EMIT_NBR;
				end else begin
					cmd.rd_next = 1'b1;
				end
			end
			ST_EMIT_SRV: begin
				if (out_free) begin
					cmd.out_srv = 1'b1;
					state_nxt   = ST_IDLE;
				end
			end
			ST_EMIT_NBR: begin
				if (out_free) begin
					cmd.out_nbr = 1'b1;
					state_nxt   = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// advance state, hold the result flag until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_srv || cmd.out_nbr) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/wcdma_cmt_dp.sv =====
`default_nettype none
module wcdma_cmt_dp #(
	parameter int NBR_DEPTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire wcdma_cmt_pkg::dp_cmd_t cmd,
	output wcdma_cmt_pkg::dp_sts_t      sts,
	input  wire logic [1:0]             kind,
	input  wire logic [15:0]            uarfcn,
	input  wire logic [15:0]            psc,
	input  wire logic signed [7:0]      rscp_in,
	input  wire logic signed [7:0]      ecio_in,
	input  wire logic [31:0]            cell_ident,
	input  wire logic [15:0]            area_code,
	input  wire logic [11:0]            mcc_nibbles,
	input  wire logic [11:0]            mnc_nibbles,
	output logic [15:0]                 rep_uarfcn,
	output logic [15:0]                 rep_psc,
	output logic signed [8:0]           rep_rscp,
	output logic signed [6:0]           rep_ecno_db,
	output logic                        rep_serving,
	output logic [27:0]                 rep_cell_ident,
	output logic [15:0]                 rep_area_code,
	output logic [9:0]                  rep_mcc,
	output logic [9:0]                  rep_mnc,
	output logic                        table_full
);

	localparam int IDX_W = (NBR_DEPTH > 1) ? $clog2(NBR_DEPTH) : 1;
	localparam int CNT_W = $clog2(NBR_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NBR_DEPTH);

	// three BCD digits, first in the top nibble; filler ends, non-digits skip
	function automatic logic [9:0] bcd3(input logic [11:0] nib);
		logic [9:0] r;
		logic       stop;
		logic [3:0] d;
		r    = '0;
		stop = 1'b0;
		for (int i = 0; i < 3; i++) begin
			d = nib[11 - 4*i -: 4];
			if (d == wcdma_cmt_pkg::DIGIT_END) begin
				stop = 1'b1;
			end else if (!stop && d <= wcdma_cmt_pkg::DIGIT_MAX) begin
				r = 10'(r * 10 + d);
			end
		end
		return r;
	endfunction

	// RSCP magnitude: raw minus offset, clamped to 0..floor
	function automatic logic [7:0] rscp_mag(input logic signed [7:0] raw);
		logic signed [8:0] r;
		logic signed [8:0] n;
		r = 9'(raw) - 9'sd21;
		n = -r;
		if (r > 9'sd0) begin
			return 8'd0;
		end else if (n > 9'(wcdma_cmt_pkg::RSCP_FLOOR)) begin
			return 8'(wcdma_cmt_pkg::RSCP_FLOOR);
		end else begin
			return n[7:0];
		end
	endfunction

	// Ec/No magnitude: halve toward zero, clamp to 0..floor
	function automatic logic [5:0] ecno_mag(input logic signed [7:0] raw);
		logic signed [8:0] n;
		logic [7:0]        h;
		n = -(9'(raw));
		h = n[8:1];
		if (!raw[7]) begin
			return 6'd0;
		end else if (h > 8'(wcdma_cmt_pkg::ECNO_FLOOR)) begin
			return 6'(wcdma_cmt_pkg::ECNO_FLOOR);
		end else begin
			return h[5:0];
		end
	endfunction

	// request registers
	logic [1:0]  kind_q;
	logic [15:0] uarfcn_q, psc_q;
	logic [7:0]  rmag_q;
	logic [5:0]  emag_q;
	logic [27:0] ident_q;
	logic [15:0] area_q;
	logic [11:0] mcc_nib_q, mnc_nib_q;

	// serving cell state
	logic [15:0] srv_uarfcn_q, srv_psc_q, srv_area_q;
	logic [27:0] srv_ident_q;
	logic [9:0]  srv_mcc_q, srv_mnc_q;
	logic [7:0]  srv_rscp_q;
	logic [5:0]  srv_ecno_q;
	logic        srv_flag_q;

	// neighbor table: valid entries are always a prefix of fill count
	logic [31:0]      nbr_mem [NBR_DEPTH];
	logic [31:0]      rd_data_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] rd_addr;
	logic [9:0]       mcc_dec, mnc_dec;
	logic             full;

	assign mcc_dec = bcd3(mcc_nib_q);
	assign mnc_dec = bcd3(mnc_nib_q);
	assign full    = (count_q == CNT_FULL);
	assign rd_addr = cmd.rd_start ? '0 : IDX_W'(idx_q + 1'b1);

	// status toward the controller
	always_comb begin
		sts.ident_ok  = (kind_q == wcdma_cmt_pkg::KIND_IDENT) ||
			((kind_q == wcdma_cmt_pkg::KIND_SERV) && (mcc_dec != '0) &&
			 (psc_q <= 16'(wcdma_cmt_pkg::PSC_MAX)));
		sts.is_meas   = (kind_q == wcdma_cmt_pkg::KIND_MEAS);
		sts.srv_match = (srv_uarfcn_q != '0) && (srv_uarfcn_q == uarfcn_q) &&
			(srv_psc_q == psc_q);
		sts.tbl_empty = (count_q == '0);
		sts.hit       = (rd_data_q == {uarfcn_q, psc_q});
		sts.last      = (CNT_W'(idx_q) == CNT_W'(count_q - 1'b1));
	end

	// capture the request, converting signal values on the way in
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q    <= kind;
			uarfcn_q  <= uarfcn;
			psc_q     <= (kind == wcdma_cmt_pkg::KIND_IDENT) ? (psc >> 4) : psc;
			rmag_q    <= rscp_mag(rscp_in);
			emag_q    <= ecno_mag(ecio_in);
			ident_q   <= cell_ident[wcdma_cmt_pkg::IDENT_W-1:0];
			area_q    <= area_code;
			mcc_nib_q <= mcc_nibbles;
			mnc_nib_q <= mnc_nibbles;
		end
	end

	// update the serving cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srv_uarfcn_q <= '0;
			srv_psc_q    <= '0;
			srv_ident_q  <= '0;
			srv_area_q   <= '0;
			srv_mcc_q    <= '0;
			srv_mnc_q    <= '0;
			srv_rscp_q   <= '0;
			srv_ecno_q   <= '0;
			srv_flag_q   <= 1'b0;
		end else begin
			if (cmd.srv_id_upd) begin
				srv_uarfcn_q <= uarfcn_q;
				srv_psc_q    <= psc_q;
				srv_ident_q  <= ident_q;
				srv_area_q   <= area_q;
				srv_mcc_q    <= mcc_dec;
				srv_mnc_q    <= mnc_dec;
				srv_flag_q   <= 1'b1;
			end
			if (cmd.srv_meas_upd) begin
				srv_rscp_q <= rmag_q;
				srv_ecno_q <= emag_q;
			end
		end
	end

	// scan the table one entry per cycle; append a new neighbor while the table is not full
	always_ff @(posedge clk) begin
		if (cmd.rd_start || cmd.rd_next) begin
			rd_data_q <= nbr_mem[rd_addr];
		end
		if (cmd.out_nbr && !full) begin
			nbr_mem[count_q[IDX_W-1:0]] <= {uarfcn_q, psc_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			count_q <= '0;
		end else begin
			if (cmd.rd_start || cmd.rd_next) begin
				idx_q <= rd_addr;
			end
			if (cmd.out_nbr && !full) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// load the report register
	always_ff @(posedge clk) begin
		if (cmd.out_srv) begin
			rep_uarfcn     <= srv_uarfcn_q;
			rep_psc        <= srv_psc_q;
			rep_rscp       <= 9'sd0 - 9'({1'b0, srv_rscp_q});
			rep_ecno_db    <= 7'sd0 - 7'({1'b0, srv_ecno_q});
			rep_serving    <= srv_flag_q;
			rep_cell_ident <= srv_ident_q;
			rep_area_code  <= srv_area_q;
			rep_mcc        <= srv_mcc_q;
			rep_mnc        <= srv_mnc_q;
			table_full     <= 1'b0;
		end else if (cmd.out_nbr) begin
			rep_uarfcn     <= uarfcn_q;
			rep_psc        <= psc_q;
			rep_rscp       <= 9'sd0 - 9'({1'b0, rmag_q});
			rep_ecno_db    <= 7'sd0 - 7'({1'b0, emag_q});
			rep_serving    <= 1'b0;
			rep_cell_ident <= '0;
			rep_area_code  <= '0;
			rep_mcc        <= '0;
			rep_mnc        <= '0;
			table_full     <= full;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/wcdma_cell_measurement_table.sv =====
// Identity records and serving-cell measurements pass decode and the emit state into a report;
// a new neighbor is reported after a scan of the N = fill count entries, one entry per cycle.
// A new request is taken only in idle, once the last one is done: the neighbor memory scan
// and a pending report that is not taken, which holds the emit state, both delay it.
// Reset (arst_n, asynchronous): clears serving state, fill count and handshake;
// table contents are not cleared, entries at or above the fill count are never read.
`default_nettype none
module wcdma_cell_measurement_table #(
	parameter int NBR_DEPTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        kind,
	input  wire logic [15:0]       uarfcn,
	input  wire logic [15:0]       psc,
	input  wire logic signed [7:0] rscp_in,
	input  wire logic signed [7:0] ecio_in,
	input  wire logic [31:0]       cell_ident,
	input  wire logic [15:0]       area_code,
	input  wire logic [11:0]       mcc_nibbles,
	input  wire logic [11:0]       mnc_nibbles,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [15:0]            rep_uarfcn,
	output logic [15:0]            rep_psc,
	output logic signed [8:0]      rep_rscp,
	output logic signed [6:0]      rep_ecno_db,
	output logic                   rep_serving,
	output logic [27:0]            rep_cell_ident,
	output logic [15:0]            rep_area_code,
	output logic [9:0]             rep_mcc,
	output logic [9:0]             rep_mnc,
	output logic                   table_full
);

	wcdma_cmt_pkg::dp_cmd_t cmd;
	wcdma_cmt_pkg::dp_sts_t sts;

	wcdma_cmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	wcdma_cmt_dp #(
		.NBR_DEPTH (NBR_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.kind           (kind),
		.uarfcn         (uarfcn),
		.psc            (psc),
		.rscp_in        (rscp_in),
		.ecio_in        (ecio_in),
		.cell_ident     (cell_ident),
		.area_code      (area_code),
		.mcc_nibbles    (mcc_nibbles),
		.mnc_nibbles    (mnc_nibbles),
		.rep_uarfcn     (rep_uarfcn),
		.rep_psc        (rep_psc),
		.rep_rscp       (rep_rscp),
		.rep_ecno_db    (rep_ecno_db),
		.rep_serving    (rep_serving),
		.rep_cell_ident (rep_cell_ident),
		.rep_area_code  (rep_area_code),
		.rep_mcc        (rep_mcc),
		.rep_mnc        (rep_mnc),
		.table_full     (table_full)
	);

`ifndef SYNTHESIS
	// one request in flight: no accept right after an accept
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while another is in flight");

	// at most one report source per cycle
	a_one_report: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.out_srv && cmd.out_nbr))
		else $error("serving and neighbor report loaded together");

	// a loaded report is offered next cycle
	a_report_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_srv || cmd.out_nbr) |=> out_valid)
		else $error("report loaded but not offered");

	// the scan never reads past the last filled entry
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_next |-> (!sts.last && !sts.hit))
		else $error("table scan advanced past its end");
`endif

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0]  KIND_IDENT  = wcdma_cmt_pkg::KIND_IDENT;
	localparam logic [1:0]  KIND_SERV   = wcdma_cmt_pkg::KIND_SERV;
	localparam logic [1:0]  KIND_MEAS   = wcdma_cmt_pkg::KIND_MEAS;
	localparam int unsigned RSCP_OFFSET = wcdma_cmt_pkg::RSCP_OFFSET;
	localparam int unsigned RSCP_FLOOR  = wcdma_cmt_pkg::RSCP_FLOOR;
	localparam int unsigned ECNO_FLOOR  = wcdma_cmt_pkg::ECNO_FLOOR;
	localparam int unsigned PSC_MAX     = wcdma_cmt_pkg::PSC_MAX;
	localparam int unsigned IDENT_W     = wcdma_cmt_pkg::IDENT_W;
	localparam logic [3:0]  DIGIT_END   = wcdma_cmt_pkg::DIGIT_END;
	localparam logic [3:0]  DIGIT_MAX   = wcdma_cmt_pkg::DIGIT_MAX;

	localparam int NBR_SLOTS = 32;
	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam int N_DIRECTED = 21;
	localparam int RANDOM_ITEMS = 1330;
	localparam int KEY_POOL = 48;
	localparam int HOLD_AT = 1150;
	localparam int HOLD_LEN = 400;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SHOWN_MISMATCHES = 10;

	typedef struct packed {
		logic [1:0]        kind;
		logic [15:0]       uarfcn;
		logic [15:0]       psc;
		logic signed [7:0] rscp_in;
		logic signed [7:0] ecio_in;
		logic [31:0]       cell_ident;
		logic [15:0]       area_code;
		logic [11:0]       mcc_nibbles;
		logic [11:0]       mnc_nibbles;
	} meas_rec_t;

	typedef struct packed {
		logic [15:0]       uarfcn;
		logic [15:0]       psc;
		logic signed [8:0] rscp_lvl;
		logic signed [6:0] ecno_db;
		logic              serving;
		logic [27:0]       cell_ident;
		logic [15:0]       area_code;
		logic [9:0]        mcc;
		logic [9:0]        mnc;
		logic              full;
	} cell_rep_t;

	// how a directed row is checked: by the predictor, a typed report, or no report
	typedef enum logic [1:0] {CHK_MODEL, CHK_REPORT, CHK_SILENT} check_e;

	typedef struct packed {
		meas_rec_t rec;
		check_e    chk;
		cell_rep_t rep;
	} directed_row_t;

	localparam cell_rep_t NO_REP = '0;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] kind;
	logic [15:0] uarfcn;
	logic [15:0] psc;
	logic signed [7:0] rscp_in;
	logic signed [7:0] ecio_in;
	logic [31:0] cell_ident;
	logic [15:0] area_code;
	logic [11:0] mcc_nibbles;
	logic [11:0] mnc_nibbles;
	logic out_valid;
	logic out_ready;
	logic [15:0] rep_uarfcn;
	logic [15:0] rep_psc;
	logic signed [8:0] rep_rscp;
	logic signed [6:0] rep_ecno_db;
	logic rep_serving;
	logic [27:0] rep_cell_ident;
	logic [15:0] rep_area_code;
	logic [9:0] rep_mcc;
	logic [9:0] rep_mnc;
	logic table_full;

	// serving cell and neighbor table as the predictor sees them
	logic [15:0] srv_uarfcn, srv_psc, srv_area;
	logic [27:0] srv_ident;
	logic [9:0] srv_mcc, srv_mnc;
	int srv_rscp, srv_ecno;
	bit srv_flag;
	bit nb_used [NBR_SLOTS];
	logic [15:0] nb_uarfcn [NBR_SLOTS];
	logic [15:0] nb_psc [NBR_SLOTS];
	int nb_rscp [NBR_SLOTS];
	int nb_ecno [NBR_SLOTS];

	cell_rep_t pending_reports [$];
	logic [15:0] key_uarfcn [KEY_POOL];
	logic [15:0] key_psc [KEY_POOL];
	int mismatches = 0;
	int accepted_items = 0;
	int counted_items = 0;
	int send_idle_pct = 26;
	int recv_idle_pct = 50;
	int cycle_count = 0;

	directed_row_t directed_rows [N_DIRECTED] = '{
		'{'{KIND_MEAS, 16'd0, 16'd0, 8'sd0, 8'sd0, 32'd0, 16'd0, 12'h000, 12'h000}, CHK_REPORT,
			'{16'd0, 16'd0, -9'sd21, 7'sd0, 1'b0, 28'd0, 16'd0, 10'd0, 10'd0, 1'b0}},
		'{'{KIND_MEAS, 16'd0, 16'd0, 8'sh80, 8'sh80, 32'd0, 16'd0, 12'h000, 12'h000}, CHK_SILENT,
			NO_REP},
		'{'{KIND_MEAS, 16'hFFFF, 16'hFFFF, 8'sh7F, 8'sh7F, 32'hFFFFFFFF, 16'hFFFF, 12'hFFF,
			12'hFFF}, CHK_REPORT,
			'{16'hFFFF, 16'hFFFF, 9'sd0, 7'sd0, 1'b0, 28'd0, 16'd0, 10'd0, 10'd0, 1'b0}},
		'{'{KIND_MEAS, 16'd100, 16'd200, 8'sh80, 8'sh80, 32'd0, 16'd0, 12'h000, 12'h000},
			CHK_REPORT,
			'{16'd100, 16'd200, -9'sd140, -7'sd50, 1'b0, 28'd0, 16'd0, 10'd0, 10'd0, 1'b0}},
		'{'{KIND_MEAS, 16'd101, 16'd1, 8'sd21, 8'shFF, 32'd0, 16'd0, 12'h000, 12'h000},
			CHK_REPORT,
			'{16'd101, 16'd1, 9'sd0, 7'sd0, 1'b0, 28'd0, 16'd0, 10'd0, 10'd0, 1'b0}},
		'{'{KIND_MEAS, 16'd102, 16'd2, 8'sh89, 8'shFD, 32'd0, 16'd0, 12'h000, 12'h000},
			CHK_REPORT,
			'{16'd102, 16'd2, -9'sd140, -7'sd1, 1'b0, 28'd0, 16'd0, 10'd0, 10'd0, 1'b0}},
		'{'{KIND_NONE, 16'hFFFF, 16'hFFFF, 8'shFF, 8'shFF, 32'hFFFFFFFF, 16'hFFFF, 12'hFFF,
			12'hFFF}, CHK_SILENT, NO_REP},
		'{'{KIND_SERV, 16'd10700, 16'd5, 8'sd0, 8'sd0, 32'd1, 16'd1, 12'h000, 12'h010},
			CHK_SILENT, NO_REP},
		'{'{KIND_SERV, 16'd10700, 16'd512, 8'sd0, 8'sd0, 32'd1, 16'd1, 12'h250, 12'h010},
			CHK_SILENT, NO_REP},
		'{'{KIND_SERV, 16'd10700, 16'd511, 8'sd0, 8'sd0, 32'hFFFFFFFF, 16'hFFFF, 12'h999,
			12'hFFF}, CHK_REPORT,
			'{16'd10700, 16'd511, 9'sd0, 7'sd0, 1'b1, 28'hFFFFFFF, 16'hFFFF, 10'd999, 10'd0,
			1'b0}},
		'{'{KIND_MEAS, 16'd10700, 16'd511, 8'shCE, 8'shEC, 32'd0, 16'd0, 12'h000, 12'h000},
			CHK_REPORT,
			'{16'd10700, 16'd511, -9'sd71, -7'sd10, 1'b1, 28'hFFFFFFF, 16'hFFFF, 10'd999,
			10'd0, 1'b0}},
		'{'{KIND_IDENT, 16'd10700, 16'hFFFF, 8'sd0, 8'sd0, 32'hF0000000, 16'd0, 12'h2F5,
			12'hA1B}, CHK_REPORT,
			'{16'd10700, 16'd4095, -9'sd71, -7'sd10, 1'b1, 28'd0, 16'd0, 10'd2, 10'd1, 1'b0}},
		'{'{KIND_IDENT, 16'd0, 16'h000F, 8'sd0, 8'sd0, 32'h01234567, 16'h1234, 12'h000,
			12'h01F}, CHK_MODEL, NO_REP},
		'{'{KIND_MEAS, 16'd0, 16'd0, 8'sd0, 8'sd0, 32'd0, 16'd0, 12'h000, 12'h000}, CHK_SILENT,
			NO_REP},
		'{'{KIND_SERV, 16'd1, 16'd0, 8'sd0, 8'sd0, 32'd5, 16'd7, 12'h310, 12'h260}, CHK_MODEL,
			NO_REP},
		'{'{KIND_MEAS, 16'd1, 16'd0, -8'sd100, -8'sd60, 32'd0, 16'd0, 12'h000, 12'h000},
			CHK_MODEL, NO_REP},
		'{'{KIND_SERV, 16'd2, 16'd3, 8'sd0, 8'sd0, 32'd9, 16'd9, 12'hCDE, 12'h111}, CHK_SILENT,
			NO_REP},
		'{'{KIND_SERV, 16'd2, 16'd3, 8'sd0, 8'sd0, 32'd9, 16'd9, 12'hF12, 12'h111}, CHK_SILENT,
			NO_REP},
		'{'{KIND_IDENT, 16'd500, 16'h1230, 8'sd0, 8'sd0, 32'h0ABCDEF0, 16'h5A5A, 12'h12F,
			12'h1F2}, CHK_MODEL, NO_REP},
		'{'{KIND_MEAS, 16'd200, 16'd300, 8'sd22, 8'sd1, 32'd0, 16'd0, 12'h000, 12'h000},
			CHK_MODEL, NO_REP},
		'{'{KIND_MEAS, 16'd500, 16'h0123, -8'sd40, -8'sd7, 32'd0, 16'd0, 12'h000, 12'h000},
			CHK_MODEL, NO_REP}
	};

	wcdma_cell_measurement_table #(
		.NBR_DEPTH(NBR_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.uarfcn(uarfcn),
		.psc(psc),
		.rscp_in(rscp_in),
		.ecio_in(ecio_in),
		.cell_ident(cell_ident),
		.area_code(area_code),
		.mcc_nibbles(mcc_nibbles),
		.mnc_nibbles(mnc_nibbles),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.rep_uarfcn(rep_uarfcn),
		.rep_psc(rep_psc),
		.rep_rscp(rep_rscp),
		.rep_ecno_db(rep_ecno_db),
		.rep_serving(rep_serving),
		.rep_cell_ident(rep_cell_ident),
		.rep_area_code(rep_area_code),
		.rep_mcc(rep_mcc),
		.rep_mnc(rep_mnc),
		.table_full(table_full)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// decode three BCD digits, stop at the end marker, skip other non-digits
	function automatic logic [9:0] bcd_value(logic [11:0] nib);
		int unsigned acc;
		logic [3:0] d;
		bit done;
		acc = 0;
		done = 0;
		for (int i = 0; i < 3; i++) begin
			d = nib[11 - 4 * i -: 4];
			if (d == DIGIT_END)
				done = 1;
			if (!done && d <= DIGIT_MAX)
				acc = acc * 10 + d;
		end
		return acc[9:0];
	endfunction

	function automatic cell_rep_t serving_report();
		cell_rep_t rep;
		rep.uarfcn = srv_uarfcn;
		rep.psc = srv_psc;
		rep.rscp_lvl = srv_rscp[8:0];
		rep.ecno_db = srv_ecno[6:0];
		rep.serving = srv_flag;
		rep.cell_ident = srv_ident;
		rep.area_code = srv_area;
		rep.mcc = srv_mcc;
		rep.mnc = srv_mnc;
		rep.full = 1'b0;
		return rep;
	endfunction

	function automatic string rep_text(cell_rep_t r);
		return {$sformatf("ch %0d psc %0d rscp %0d ecno %0d srv %0b ",
				r.uarfcn, r.psc, r.rscp_lvl, r.ecno_db, r.serving),
			$sformatf("id %h lac %h mcc %0d mnc %0d full %0b",
				r.cell_ident, r.area_code, r.mcc, r.mnc, r.full)};
	endfunction

	// advance the cell state by one record and work out the report it causes
	task automatic predict_cell_report(input meas_rec_t r, output bit has_rep,
			output cell_rep_t rep);
		logic [9:0] mcc, mnc;
		int rscp, ecno, slot;
		bit known;
		has_rep = 0;
		rep = '0;
		case (r.kind)
			KIND_IDENT, KIND_SERV: begin
				mcc = bcd_value(r.mcc_nibbles);
				mnc = bcd_value(r.mnc_nibbles);
				if (r.kind == KIND_IDENT || (mcc != 0 && r.psc <= PSC_MAX)) begin
					srv_uarfcn = r.uarfcn;
					srv_psc = (r.kind == KIND_IDENT) ? (r.psc >> 4) : r.psc;
					srv_ident = r.cell_ident[IDENT_W - 1:0];
					srv_area = r.area_code;
					srv_mcc = mcc;
					srv_mnc = mnc;
					srv_flag = 1;
					has_rep = 1;
					rep = serving_report();
				end
			end
			KIND_MEAS: begin
				rscp = int'($signed(r.rscp_in)) - int'(RSCP_OFFSET);
				ecno = int'($signed(r.ecio_in)) / 2;
				if (rscp < -int'(RSCP_FLOOR))
					rscp = -int'(RSCP_FLOOR);
				if (rscp > 0)
					rscp = 0;
				if (ecno < -int'(ECNO_FLOOR))
					ecno = -int'(ECNO_FLOOR);
				if (ecno > 0)
					ecno = 0;
				if (srv_uarfcn != 0 && srv_uarfcn == r.uarfcn && srv_psc == r.psc) begin
					srv_rscp = rscp;
					srv_ecno = ecno;
					has_rep = 1;
					rep = serving_report();
				end else begin
					// merge into the first matching neighbor, else take the lowest free slot
					slot = -1;
					known = 0;
					for (int i = 0; i < NBR_SLOTS; i++) begin
						if (!known) begin
							if (nb_used[i]) begin
								if (nb_uarfcn[i] == r.uarfcn && nb_psc[i] == r.psc) begin
									nb_rscp[i] = rscp;
									nb_ecno[i] = ecno;
									known = 1;
								end
							end else if (slot < 0) begin
								slot = i;
							end
						end
					end
					if (!known) begin
						has_rep = 1;
						rep.uarfcn = r.uarfcn;
						rep.psc = r.psc;
						rep.rscp_lvl = rscp[8:0];
						rep.ecno_db = ecno[6:0];
						rep.full = (slot < 0);
						if (slot >= 0) begin
							nb_used[slot] = 1;
							nb_uarfcn[slot] = r.uarfcn;
							nb_psc[slot] = r.psc;
							nb_rscp[slot] = rscp;
							nb_ecno[slot] = ecno;
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	// offer one request, wait for its accept, then queue what it should report
	task automatic send_record(input meas_rec_t r, input check_e chk, input cell_rep_t typed);
		bit has_rep;
		cell_rep_t rep;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		kind <= r.kind;
		uarfcn <= r.uarfcn;
		psc <= r.psc;
		rscp_in <= r.rscp_in;
		ecio_in <= r.ecio_in;
		cell_ident <= r.cell_ident;
		area_code <= r.area_code;
		mcc_nibbles <= r.mcc_nibbles;
		mnc_nibbles <= r.mnc_nibbles;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		accepted_items++;
		if (r.kind != KIND_NONE)
			counted_items++;
		predict_cell_report(r, has_rep, rep);
		case (chk)
			CHK_MODEL: if (has_rep) pending_reports = {pending_reports, rep};
			CHK_REPORT: pending_reports = {pending_reports, typed};
			default: ;
		endcase
	endtask

	// build one random record, mostly well-formed and aimed at known cells
	task automatic make_random_record(output meas_rec_t r);
		int pick, k;
		r.kind = KIND_MEAS;
		r.uarfcn = 16'($urandom);
		r.psc = 16'($urandom);
		r.rscp_in = 8'($urandom);
		r.ecio_in = 8'($urandom);
		r.cell_ident = $urandom;
		r.area_code = 16'($urandom);
		r.mcc_nibbles = 12'($urandom);
		r.mnc_nibbles = 12'($urandom);
		pick = $urandom_range(99);
		if (pick < 3) begin
			r.kind = KIND_NONE;
		end else if (pick < 14) begin
			r.kind = KIND_IDENT;
		end else if (pick < 26) begin
			r.kind = KIND_SERV;
			if ($urandom_range(4) != 0) begin
				r.psc = 16'($urandom_range(PSC_MAX));
				r.mcc_nibbles = {4'($urandom_range(1, 9)), 4'($urandom_range(9)),
					4'($urandom_range(9))};
				r.mnc_nibbles = {4'($urandom_range(9)), 4'($urandom_range(9)),
					$urandom_range(1) ? DIGIT_END : 4'($urandom_range(9))};
			end
		end else if (pick < 54) begin
			r.uarfcn = srv_uarfcn;
			r.psc = srv_psc;
		end else if (pick < 92) begin
			k = $urandom_range(KEY_POOL - 1);
			r.uarfcn = key_uarfcn[k];
			r.psc = key_psc[k];
		end
	endtask

	// receiver: random stalls, plus one long hold-off to back up the block
	initial begin
		int stall_left;
		bit held_off;
		stall_left = 0;
		held_off = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_off && counted_items >= HOLD_AT) begin
				held_off = 1;
				stall_left = HOLD_LEN;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// compare each report with the oldest expectation
	always @(posedge clk) begin : report_check
		cell_rep_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{rep_uarfcn, rep_psc, rep_rscp, rep_ecno_db, rep_serving,
				rep_cell_ident, rep_area_code, rep_mcc, rep_mnc, table_full};
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("unexpected report: %s", rep_text(got));
			end else begin
				want = pending_reports.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= SHOWN_MISMATCHES)
						$display("report mismatch\n  expected %s\n  actual   %s",
							rep_text(want), rep_text(got));
				end
			end
		end
	end

	// stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		meas_rec_t r;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = '0;
		uarfcn = '0;
		psc = '0;
		rscp_in = '0;
		ecio_in = '0;
		cell_ident = '0;
		area_code = '0;
		mcc_nibbles = '0;
		mnc_nibbles = '0;
		srv_uarfcn = '0;
		srv_psc = '0;
		srv_area = '0;
		srv_ident = '0;
		srv_mcc = '0;
		srv_mnc = '0;
		srv_rscp = 0;
		srv_ecno = 0;
		srv_flag = 0;
		for (int i = 0; i < NBR_SLOTS; i++)
			nb_used[i] = 0;
		// neighbor keys: more than the table holds, so it fills and overflows
		for (int i = 0; i < KEY_POOL; i++) begin
			key_uarfcn[i] = 16'($urandom_range(10562, 10838));
			key_psc[i] = 16'($urandom_range(PSC_MAX));
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int n = 0; n < N_DIRECTED; n++)
			send_record(directed_rows[n].rec, directed_rows[n].chk, directed_rows[n].rep);

		while (counted_items < N_DIRECTED + RANDOM_ITEMS) begin
			// idle phases: sender light, then receiver light, then none
			if (counted_items < 460) begin
				send_idle_pct = 26;
				recv_idle_pct = 50;
			end else if (counted_items < 920) begin
				send_idle_pct = 50;
				recv_idle_pct = 26;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			make_random_record(r);
			send_record(r, CHK_MODEL, NO_REP);
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// drain, then give the block time to show any stray report
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_reports.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
`default_nettype wire
